[hw/rtl/wul_pkg.sv]
// Shared types and codes for the windowed usage limiter.
`timescale 1ns / 1ps

package wul_pkg;

    // Fixed field widths
    localparam int REQ_W    = 2;
    localparam int RC_W     = 2;
    localparam int DIG_W    = 64;
    localparam int WEIGHT_W = 16;
    localparam int ACT_W    = 2;
    localparam int LIMIT_W  = 24;
    localparam int WSLOT_W  = 5;
    localparam int THR_W    = 5;
    localparam int PEN_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Request types
    localparam logic [REQ_W-1:0] REQ_USAGE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

    // Usage outcome classes
    localparam logic [RC_W-1:0] RC_FOUND    = 2'd0;
    localparam logic [RC_W-1:0] RC_NOTFOUND = 2'd1;
    localparam logic [RC_W-1:0] RC_FAKE     = 2'd2;

    // Penalty modes
    localparam logic [PEN_W-1:0] PEN_NONE   = 2'd0;
    localparam logic [PEN_W-1:0] PEN_FAKE   = 2'd1;
    localparam logic [PEN_W-1:0] PEN_BANNED = 2'd2;
    localparam logic [PEN_W-1:0] PEN_DELAY  = 2'd3;

    // Check actions
    localparam logic [ACT_W-1:0] ACT_PASS  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FAKE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELAY = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY   = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DECIDE,
        ST_MOD,
        ST_DONE
    } wul_state_t;

endpackage

[hw/rtl/windowed_usage_limiter.sv]
// Windowed usage limiter: usage counting, period ring and deny control.
`timescale 1ns / 1ps

//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+--------------------------------
//  s_       | s_valid/s_ready, s_req_type, s_result_... | one request word in
//  m_       | m_valid/m_ready, m_action, m_denied       | one result word per request
//  cfg_     | cfg_wr_en, cfg_index, cfg_wdata           | register writes, no handshake
//
//  Usage events and checks: the request passes ST_EXEC and ST_DONE, and the result is registered.
//  A scanning period tick runs ST_EXEC, ST_SCAN, ST_DECIDE, then ST_MOD only when deny was clear
//  and stays clear (ring scan one slot a cycle through the single memory read port); a stale
//  index makes ST_MOD subtract the window once more per wrap. Ticks that skip the scan go to ST_MOD or ST_DONE.
//  One request at a time: s_ready is high only while the sequencer idles; a result waiting on
//  m_ready holds the sequencer in its final state.
//  Reset (aresetn low, synchronous) clears control state, config and the slot valid bits;
//  slots never written since reset read as zero.

module windowed_usage_limiter #(
    parameter int MAX_SLOTS   = 16,
    parameter int COUNT_BITS  = 24,
    parameter int DIGEST_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [wul_pkg::REQ_W-1:0]       s_req_type,
    input  logic [wul_pkg::RC_W-1:0]        s_result_class,
    input  logic [wul_pkg::DIG_W-1:0]       s_request_digest,
    input  logic [wul_pkg::WEIGHT_W-1:0]    s_usage_weight,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wul_pkg::ACT_W-1:0]       m_action,
    output logic                            m_denied,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [wul_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wul_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
    import wul_pkg::*;

    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
    localparam int DATA_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam int ALU_W  = DATA_W + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // ---------------- configuration registers ----------------
    logic                  enabled_reg;
    logic [LIMIT_W-1:0]    usage_limit_reg;
    logic [WSLOT_W-1:0]    window_slots_reg;
    logic [THR_W-1:0]      deny_threshold_reg;
    logic [PEN_W-1:0]      penalty_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg        <= 1'b0;
            usage_limit_reg    <= '0;
            window_slots_reg   <= WSLOT_W'(10);
            deny_threshold_reg <= THR_W'(8);
            penalty_mode_reg   <= PEN_NONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLED:   enabled_reg        <= cfg_wdata[0];
                CFG_LIMIT:     usage_limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                CFG_WINDOW:    window_slots_reg   <= cfg_wdata[WSLOT_W-1:0];
                CFG_THRESHOLD: deny_threshold_reg <= cfg_wdata[THR_W-1:0];
                CFG_PENALTY:   penalty_mode_reg   <= cfg_wdata[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective window: zero acts as one, oversize clamps to the ring depth
    logic [SLOT_W-1:0] slots_eff;
    always_comb begin
        if (window_slots_reg == '0)
            slots_eff = SLOT_W'(1);
        else if (int'(window_slots_reg) > MAX_SLOTS)
            slots_eff = SLOT_W'(MAX_SLOTS);
        else
            slots_eff = SLOT_W'(window_slots_reg);
    end

    logic active;
    assign active = enabled_reg && (usage_limit_reg != '0);

    // ---------------- state ----------------
    wul_state_t state_reg, state_next;

    logic [REQ_W-1:0]       req_reg, req_next;
    logic [RC_W-1:0]        rc_reg, rc_next;
    logic [DIGEST_BITS-1:0] digest_reg, digest_next;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;

    logic [COUNT_BITS-1:0]  running_reg, running_next;
    logic                   deny_reg, deny_next;
    logic [DIGEST_BITS-1:0] last_digest_reg, last_digest_next;
    logic [IDX_W-1:0]       slot_index_reg, slot_index_next;

    logic [SLOT_W-1:0]      scan_j_reg, scan_j_next;
    logic                   pend_reg, pend_next;
    logic [SLOT_W-1:0]      exceeds_reg, exceeds_next;
    logic [SLOT_W-1:0]      mod_reg, mod_next;

    logic                   m_valid_reg, m_valid_next;
    logic [ACT_W-1:0]       m_action_reg, m_action_next;
    logic                   m_denied_reg, m_denied_next;

    // ---------------- period ring memory ----------------
    logic [COUNT_BITS-1:0]  ring_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]   ring_vld_reg;
    logic                   wr_en, rd_en;
    logic [COUNT_BITS-1:0]  wr_data;
    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_BITS-1:0]  rd_data_reg;
    logic                   rd_hit_reg;
    logic [COUNT_BITS-1:0]  rd_val;

    assign rd_addr = scan_j_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[slot_index_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
            rd_hit_reg  <= ring_vld_reg[rd_addr];
        end
    end

    // valid bits: a slot not written since reset reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
        end else if (wr_en) begin
            ring_vld_reg[slot_index_reg] <= 1'b1;
        end
    end

    assign rd_val = rd_hit_reg ? rd_data_reg : '0;

    // ---------------- shared add/subtract unit ----------------
    // subtract: carry out set means a >= b
    logic [ALU_W-1:0] alu_a, alu_b;
    logic             alu_sub;
    logic [ALU_W:0]   alu_sum;
    logic             alu_carry;

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ALU_W + 1)'(alu_sub);
    assign alu_carry = alu_sum[ALU_W];

    // ---------------- decode helpers ----------------
    logic is_usage, is_tick, scan_issue, out_free, add_hit;
    assign is_usage   = (req_reg == REQ_USAGE);
    assign is_tick    = (req_reg == REQ_TICK);
    assign scan_issue = (scan_j_reg < slots_eff);
    assign out_free   = !m_valid_reg || m_ready;
    assign add_hit    = active && ((rc_reg == RC_FAKE)
                      || ((rc_reg == RC_FOUND) && (digest_reg != last_digest_reg)));

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (is_tick) begin
                    if (running_reg == '0)
                        state_next = deny_reg ? ST_DONE : ST_MOD;
                    else if (penalty_mode_reg == PEN_BANNED)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (!scan_issue && !pend_reg) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = (!alu_carry && !deny_reg) ? ST_MOD : ST_DONE;
            end
            ST_MOD: begin
                if (!alu_carry) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        req_next         = req_reg;
        rc_next          = rc_reg;
        digest_next      = digest_reg;
        weight_next      = weight_reg;
        running_next     = running_reg;
        deny_next        = deny_reg;
        last_digest_next = last_digest_reg;
        slot_index_next  = slot_index_reg;
        scan_j_next      = scan_j_reg;
        pend_next        = 1'b0;
        exceeds_next     = exceeds_reg;
        mod_next         = mod_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_action_next    = m_action_reg;
        m_denied_next    = m_denied_reg;
        wr_en            = 1'b0;
        wr_data          = running_reg;
        rd_en            = 1'b0;
        alu_a            = ALU_W'(running_reg);
        alu_b            = ALU_W'(weight_reg);
        alu_sub          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    rc_next     = s_result_class;
                    digest_next = s_request_digest[DIGEST_BITS-1:0];
                    weight_next = s_usage_weight;
                end
            end
            ST_EXEC: begin
                unique case (req_reg)
                    REQ_USAGE: begin
                        // fake adds one, a fresh found digest adds its weight
                        alu_a = ALU_W'(running_reg);
                        alu_b = (rc_reg == RC_FAKE) ? ALU_W'(1) : ALU_W'(weight_reg);
                        if (add_hit) begin
                            if (alu_sum[ALU_W-1:COUNT_BITS] != '0)
                                running_next = COUNT_MAX;
                            else
                                running_next = alu_sum[COUNT_BITS-1:0];
                            if (rc_reg == RC_FOUND) last_digest_next = digest_reg;
                        end
                    end
                    REQ_TICK: begin
                        wr_en        = 1'b1;
                        wr_data      = running_reg;
                        running_next = '0;
                        scan_j_next  = '0;
                        exceeds_next = '0;
                        mod_next     = SLOT_W'(slot_index_reg) + SLOT_W'(1);
                        if (running_reg == '0)
                            deny_next = 1'b0;        // idle period
                        else if (penalty_mode_reg == PEN_BANNED)
                            deny_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                if (scan_issue) begin
                    rd_en       = 1'b1;
                    scan_j_next = scan_j_reg + SLOT_W'(1);
                    pend_next   = 1'b1;
                end
                // slot exceeds when limit - value borrows
                alu_a   = ALU_W'(usage_limit_reg);
                alu_b   = ALU_W'(rd_val);
                alu_sub = 1'b1;
                if (pend_reg && !alu_carry) exceeds_next = exceeds_reg + SLOT_W'(1);
            end
            ST_DECIDE: begin
                alu_a     = ALU_W'(exceeds_reg);
                alu_b     = ALU_W'(deny_threshold_reg);
                alu_sub   = 1'b1;
                deny_next = alu_carry;
                if (alu_carry) begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                end
            end
            ST_MOD: begin
                // wrap by repeated subtraction of the window
                alu_a   = ALU_W'(mod_reg);
                alu_b   = ALU_W'(slots_eff);
                alu_sub = 1'b1;
                if (alu_carry)
                    mod_next = alu_sum[SLOT_W-1:0];
                else
                    slot_index_next = mod_reg[IDX_W-1:0];
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_denied_next = deny_reg;
                    if (!is_usage && !is_tick && active && deny_reg
                        && (penalty_mode_reg != PEN_NONE))
                        m_action_next = (penalty_mode_reg == PEN_DELAY) ? ACT_DELAY
                                                                        : ACT_FAKE;
                    else
                        m_action_next = ACT_PASS;
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            running_reg     <= '0;
            deny_reg        <= 1'b0;
            last_digest_reg <= '0;
            slot_index_reg  <= '0;
            scan_j_reg      <= '0;
            pend_reg        <= 1'b0;
            exceeds_reg     <= '0;
            mod_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            running_reg     <= running_next;
            deny_reg        <= deny_next;
            last_digest_reg <= last_digest_next;
            slot_index_reg  <= slot_index_next;
            scan_j_reg      <= scan_j_next;
            pend_reg        <= pend_next;
            exceeds_reg     <= exceeds_next;
            mod_reg         <= mod_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // request and result words carry no reset
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        rc_reg       <= rc_next;
        digest_reg   <= digest_next;
        weight_reg   <= weight_next;
        m_action_reg <= m_action_next;
        m_denied_reg <= m_denied_next;
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_action = m_action_reg;
    assign m_denied = m_denied_reg;

endmodule

[tb/tb_top.sv]
// Self-checking bench for the windowed usage limiter: directed script, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import wul_pkg::*;

    // Codes outside the named ranges, still legal on the wires
    localparam logic [REQ_W-1:0] REQ_ODD = 2'd3;
    localparam logic [RC_W-1:0]  RC_ODD  = 2'd3;

    localparam int RING = 16;                       // MAX_SLOTS of the instance
    localparam logic [LIMIT_W-1:0] USE_MAX = '1;    // saturated period count
    localparam logic [DIG_W-1:0]   DIG_ONES = '1;
    localparam int RANDOM_WORDS = 1950;
    localparam int PHASES = 13;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             denied;
    } verdict_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DAT_W-1:0]  reg_val;
        logic [REQ_W-1:0]      req;
        logic [RC_W-1:0]       rc;
        logic [DIG_W-1:0]      dig;
        logic [WEIGHT_W-1:0]   weight;
        bit                    typed;
        verdict_t              want;
    } row_t;

    // ---------------------------------------------------------------
    // DUT wiring
    // ---------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type;
    logic [RC_W-1:0]       s_result_class;
    logic [DIG_W-1:0]      s_request_digest;
    logic [WEIGHT_W-1:0]   s_usage_weight;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ACT_W-1:0]      m_action;
    logic                  m_denied;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_wdata;

    windowed_usage_limiter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_result_class   (s_result_class),
        .s_request_digest (s_request_digest),
        .s_usage_weight   (s_usage_weight),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action         (m_action),
        .m_denied         (m_denied),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    // 10 ns clock, rising edge at 5 ns
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Limiter predictor: own copy of registers and state
    // ---------------------------------------------------------------
    logic [LIMIT_W-1:0]  slot_use [RING];   // stored per-period counts
    logic [3:0]          ring_pos;          // current slot
    logic [LIMIT_W-1:0]  open_use;          // count of the period in progress
    logic                deny_now;
    logic [DIG_W-1:0]    seen_digest;       // last digest that was charged

    logic                on_cfg;
    logic [LIMIT_W-1:0]  limit_cfg;
    logic [WSLOT_W-1:0]  window_cfg;
    logic [THR_W-1:0]    thresh_cfg;
    logic [PEN_W-1:0]    penalty_cfg;

    function automatic void limiter_reset();
        on_cfg      = 1'b0;
        limit_cfg   = '0;
        window_cfg  = 5'd10;
        thresh_cfg  = 5'd8;
        penalty_cfg = PEN_NONE;
        foreach (slot_use[i]) slot_use[i] = '0;
        ring_pos    = '0;
        open_use    = '0;
        deny_now    = 1'b0;
        seen_digest = '0;
    endfunction

    function automatic void limiter_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_ENABLED:   on_cfg      = data[0];
            CFG_LIMIT:     limit_cfg   = data[LIMIT_W-1:0];
            CFG_WINDOW:    window_cfg  = data[WSLOT_W-1:0];
            CFG_THRESHOLD: thresh_cfg  = data[THR_W-1:0];
            CFG_PENALTY:   penalty_cfg = data[PEN_W-1:0];
            default: ;
        endcase
    endfunction

    // Saturating add into the open period
    function automatic void charge_use(logic [WEIGHT_W-1:0] amount);
        logic [LIMIT_W:0] sum;
        sum = {1'b0, open_use} + (LIMIT_W + 1)'(amount);
        open_use = sum[LIMIT_W] ? USE_MAX : sum[LIMIT_W-1:0];
    endfunction

    // Period tick: store, rescan, decide deny, maybe advance
    function automatic void close_period();
        int         slots;
        int         hits;
        logic [3:0] idx;
        logic       was_denied;
        slots = (window_cfg == 0) ? 1 : (window_cfg > RING) ? RING : int'(window_cfg);
        idx = ring_pos;                 // a stale index is still used for the store
        was_denied = 1'b0;
        slot_use[idx] = open_use;
        open_use = '0;
        if (slot_use[idx] != 0) begin
            if (penalty_cfg == PEN_BANNED) begin
                deny_now = 1'b1;        // banned: no scan at all
            end else begin
                hits = 0;
                for (int j = 0; j < slots; j++)
                    if (slot_use[j] > limit_cfg) hits++;
                was_denied = deny_now;
                deny_now = (hits >= int'(thresh_cfg));
                if (deny_now) slot_use[idx] = '0;
            end
        end else if (deny_now) begin
            // idle period lifts the deny, index holds this once
            was_denied = 1'b1;
            deny_now = 1'b0;
        end
        if (!deny_now && !was_denied)
            ring_pos = 4'((int'(idx) + 1) % slots);
    endfunction

    function automatic verdict_t limiter_step(logic [REQ_W-1:0] req, logic [RC_W-1:0] rc,
                                              logic [DIG_W-1:0] dig,
                                              logic [WEIGHT_W-1:0] w);
        verdict_t v;
        logic     active;
        v.action = ACT_PASS;
        active = on_cfg && (limit_cfg != 0);
        if (req == REQ_TICK) begin
            close_period();
        end else if (req == REQ_USAGE) begin
            if (active) begin
                if (rc == RC_FAKE) charge_use(16'd1);
                // repeats of the last charged digest cost nothing
                if (rc == RC_FOUND && dig != seen_digest) begin
                    charge_use(w);
                    seen_digest = dig;
                end
            end
        end else if (active && deny_now && penalty_cfg != PEN_NONE) begin
            // checks, and the unused request code, land here
            v.action = (penalty_cfg == PEN_DELAY) ? ACT_DELAY : ACT_FAKE;
        end
        v.denied = deny_now;
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: predict on request accept, compare on result accept
    // ---------------------------------------------------------------
    verdict_t verdict_q [$];
    int       fail_count = 0;
    bit       cur_typed;            // current request word carries a typed answer
    verdict_t cur_want;

    function automatic void flag_fail(string what, verdict_t want, verdict_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns %s: expected action %0d denied %0d, got action %0d denied %0d",
                     $time, what, want.action, want.denied, got.action, got.denied);
    endfunction

    always @(posedge aclk) begin : scoreboard
        verdict_t model;
        verdict_t got;
        verdict_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                model = limiter_step(s_req_type, s_result_class, s_request_digest,
                                     s_usage_weight);
                verdict_q.push_back(cur_typed ? cur_want : model);
            end
            if (m_valid && m_ready) begin
                got.action = m_action;
                got.denied = m_denied;
                if (verdict_q.size() == 0) begin
                    flag_fail("result word with nothing outstanding", '0, got);
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) flag_fail("result mismatch", want, got);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Back-pressure: result side stalls at random
    // ---------------------------------------------------------------
    bit quiet = 1'b0;               // phase with no idling on either side
    int stall_left = 0;

    // mostly short gaps, the odd long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 6);
        return $urandom_range(15, 60);
    endfunction

    always @(negedge aclk) begin : sink_stall
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) stall_left <= gap_len();
        end
    end

    // ---------------------------------------------------------------
    // Request driver; all calls start and end at a falling edge
    // ---------------------------------------------------------------
    logic [DIG_W-1:0] last_sent_digest = '0;
    int               words_sent = 0;

    task automatic send_word(logic [REQ_W-1:0] req, logic [RC_W-1:0] rc,
                             logic [DIG_W-1:0] dig, logic [WEIGHT_W-1:0] w,
                             bit typed, verdict_t want);
        int g;
        g = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        repeat (g) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= req;
        s_result_class   <= rc;
        s_request_digest <= dig;
        s_usage_weight   <= w;
        cur_typed        <= typed;
        cur_want         <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        last_sent_digest = dig;
        words_sent++;
    endtask

    task automatic send_plain(logic [REQ_W-1:0] req, logic [RC_W-1:0] rc,
                              logic [DIG_W-1:0] dig, logic [WEIGHT_W-1:0] w);
        send_word(req, rc, dig, w, 1'b0, '0);
    endtask

    // Let every outstanding result come back, then a short settle
    task automatic drain();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        limiter_write(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Junk above the register width; the block must ignore it
    function automatic logic [CFG_DAT_W-1:0] pad_cfg(int bits, logic [CFG_DAT_W-1:0] v);
        logic [CFG_DAT_W-1:0] hi;
        hi = CFG_DAT_W'($urandom);
        hi = hi << bits;
        return hi | v;
    endfunction

    // ---------------------------------------------------------------
    // Directed script
    // ---------------------------------------------------------------
    row_t script [$];

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
        row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        script.push_back(r);
    endfunction

    function automatic void add_word(logic [REQ_W-1:0] req, logic [RC_W-1:0] rc,
                                     logic [DIG_W-1:0] dig, logic [WEIGHT_W-1:0] w,
                                     bit typed, logic [ACT_W-1:0] act, logic den);
        row_t r;
        r = '{default: '0};
        r.req    = req;
        r.rc     = rc;
        r.dig    = dig;
        r.weight = w;
        r.typed  = typed;
        r.want   = '{action: act, denied: den};
        script.push_back(r);
    endfunction

    function automatic void build_script();
        // straight out of reset: disabled, nothing charged
        add_word(REQ_CHECK, RC_FOUND, '0, '0, 1, ACT_PASS, 0);
        add_word(REQ_USAGE, RC_FOUND, DIG_ONES, 16'hFFFF, 0, ACT_PASS, 0);
        add_word(REQ_TICK, RC_FOUND, '0, '0, 1, ACT_PASS, 0);
        add_cfg(CFG_ENABLED, 24'd1);
        add_cfg(CFG_LIMIT, 24'd1);
        add_cfg(CFG_WINDOW, 24'd2);
        add_cfg(CFG_THRESHOLD, 24'd1);
        add_cfg(CFG_PENALTY, CFG_DAT_W'(PEN_FAKE));
        // digest zero matches the reset value, so no charge
        add_word(REQ_USAGE, RC_FOUND, '0, 16'd100, 0, ACT_PASS, 0);
        add_word(REQ_USAGE, RC_FOUND, 64'd1, 16'hFFFF, 0, ACT_PASS, 0);
        add_word(REQ_USAGE, RC_FAKE, 64'd1, 16'h0, 0, ACT_PASS, 0);
        add_word(REQ_USAGE, RC_NOTFOUND, 64'd2, 16'd5, 0, ACT_PASS, 0);
        add_word(REQ_USAGE, RC_ODD, 64'd3, 16'd7, 0, ACT_PASS, 0);
        add_word(REQ_TICK, RC_FOUND, '0, '0, 1, ACT_PASS, 1);
        add_word(REQ_CHECK, RC_FOUND, '0, '0, 1, ACT_FAKE, 1);
        add_word(REQ_ODD, RC_FOUND, '0, '0, 1, ACT_FAKE, 1);
        // idle period clears deny
        add_word(REQ_TICK, RC_FOUND, '0, '0, 1, ACT_PASS, 0);
        add_cfg(CFG_PENALTY, CFG_DAT_W'(PEN_DELAY));
        add_cfg(CFG_THRESHOLD, 24'd0);
        // zero threshold: any nonzero period denies
        add_word(REQ_USAGE, RC_FOUND, 64'd2, 16'd1, 0, ACT_PASS, 0);
        add_word(REQ_TICK, RC_FOUND, '0, '0, 1, ACT_PASS, 1);
        add_word(REQ_CHECK, RC_FOUND, '0, '0, 1, ACT_DELAY, 1);
        add_cfg(CFG_PENALTY, CFG_DAT_W'(PEN_NONE));
        add_word(REQ_CHECK, RC_FOUND, '0, '0, 1, ACT_PASS, 1);
        add_cfg(CFG_PENALTY, CFG_DAT_W'(PEN_BANNED));
        add_cfg(CFG_LIMIT, 24'hFFFFFF);
        // banned: any usage at all denies
        add_word(REQ_USAGE, RC_FAKE, '0, '0, 0, ACT_PASS, 0);
        add_word(REQ_TICK, RC_FOUND, '0, '0, 1, ACT_PASS, 1);
        add_word(REQ_CHECK, RC_FOUND, '0, '0, 1, ACT_FAKE, 1);
        add_word(REQ_TICK, RC_FOUND, '0, '0, 1, ACT_PASS, 0);
        // empty window acts as one slot
        add_cfg(CFG_WINDOW, 24'd0);
        add_cfg(CFG_LIMIT, 24'd1);
        add_cfg(CFG_PENALTY, CFG_DAT_W'(PEN_FAKE));
        add_cfg(CFG_THRESHOLD, 24'd16);
        add_word(REQ_USAGE, RC_FOUND, 64'hAAAA_AAAA_AAAA_AAAA, 16'h8000, 0, ACT_PASS, 0);
        add_word(REQ_TICK, RC_FOUND, '0, '0, 0, ACT_PASS, 0);
        add_word(REQ_TICK, RC_FOUND, '0, '0, 0, ACT_PASS, 0);
        // oversized window and threshold
        add_cfg(CFG_WINDOW, 24'd31);
        add_cfg(CFG_THRESHOLD, 24'd31);
        add_word(REQ_USAGE, RC_FOUND, 64'h5555_5555_5555_5555, 16'd1, 0, ACT_PASS, 0);
        add_word(REQ_TICK, RC_FOUND, '0, '0, 0, ACT_PASS, 0);
    endfunction

    // ---------------------------------------------------------------
    // Random stimulus
    // ---------------------------------------------------------------
    task automatic usage_word();
        int                  r;
        logic [RC_W-1:0]     rc;
        logic [DIG_W-1:0]    dig;
        logic [WEIGHT_W-1:0] w;
        r = $urandom_range(0, 99);
        rc = (r < 70) ? RC_FOUND : (r < 85) ? RC_FAKE : (r < 95) ? RC_NOTFOUND : RC_ODD;
        r = $urandom_range(0, 9);
        if (r < 8)       dig = {$urandom, $urandom};
        else if (r == 8) dig = last_sent_digest;          // repeat, not charged
        else             dig = $urandom_range(0, 1) ? DIG_ONES : '0;
        r = $urandom_range(0, 9);
        if (r < 5)       w = WEIGHT_W'($urandom);
        else if (r < 8)  w = WEIGHT_W'($urandom_range(0, 500));
        else if (r == 8) w = '0;
        else             w = 16'hFFFF;
        send_plain(REQ_USAGE, rc, dig, w);
    endtask

    task automatic check_word();
        send_plain(REQ_CHECK, RC_W'($urandom), {$urandom, $urandom}, WEIGHT_W'($urandom));
    endtask

    // One period: some usage, maybe checks, a tick, then checks
    task automatic run_period();
        int n;
        n = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 8);
        repeat (n) begin
            usage_word();
            if ($urandom_range(0, 4) == 0) check_word();
        end
        send_plain(REQ_TICK, RC_W'($urandom), {$urandom, $urandom}, WEIGHT_W'($urandom));
        repeat ($urandom_range(0, 2)) check_word();
    endtask

    // Enough heavy words in one period to pin the count at its ceiling
    task automatic flood_period();
        repeat (270) send_plain(REQ_USAGE, RC_FOUND, {$urandom, $urandom}, 16'hFFFF);
        send_plain(REQ_TICK, RC_FOUND, '0, '0);
        check_word();
    endtask

    task automatic run_phase(int ph);
        int                  r;
        int                  stop_at;
        logic                en;
        logic [LIMIT_W-1:0]  lim;
        logic [WSLOT_W-1:0]  win;
        logic [THR_W-1:0]    thr;
        logic [PEN_W-1:0]    pen;
        drain();
        en = ($urandom_range(0, 5) != 0);
        r = $urandom_range(0, 9);
        if (r < 5)       lim = LIMIT_W'($urandom_range(1, 400));
        else if (r < 8)  lim = LIMIT_W'($urandom_range(400, 70000));
        else if (r == 8) lim = LIMIT_W'($urandom);
        else             lim = USE_MAX;
        win = ($urandom_range(0, 3) == 0) ? WSLOT_W'($urandom_range(0, 31))
                                          : WSLOT_W'($urandom_range(1, 16));
        thr = ($urandom_range(0, 4) == 0) ? THR_W'($urandom_range(0, 31))
                                          : THR_W'($urandom_range(0, win));
        pen = PEN_W'($urandom);
        case (ph)
            0: begin en = 1; lim = LIMIT_W'($urandom_range(1, 300)); win = 16; thr = 16; end
            1: begin
                en = 1;
                lim = $urandom_range(0, 1) ? USE_MAX : USE_MAX - 1;
                thr = 1;
            end
            2: en = 0;
            3: begin en = 1; lim = '0; end
            4: begin en = 1; win = 1; thr = 1; end
            5: begin en = 1; win = 0; thr = 0; end
            6: begin en = 1; win = 31; thr = 31; end
            default: ;
        endcase
        quiet = (ph % 4 == 3);
        cfg_write(CFG_ENABLED, pad_cfg(1, CFG_DAT_W'(en)));
        cfg_write(CFG_LIMIT, lim);
        cfg_write(CFG_WINDOW, pad_cfg(WSLOT_W, CFG_DAT_W'(win)));
        cfg_write(CFG_THRESHOLD, pad_cfg(THR_W, CFG_DAT_W'(thr)));
        cfg_write(CFG_PENALTY, pad_cfg(PEN_W, CFG_DAT_W'(pen)));
        // running word budget over the whole run, flood and script included
        stop_at = ((ph + 1) * RANDOM_WORDS) / PHASES;
        if (ph == 1) flood_period();
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                run_period();
            end else begin
                // noise: any code, any field
                send_plain(REQ_W'($urandom), RC_W'($urandom), {$urandom, $urandom},
                           WEIGHT_W'($urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_req_type       = REQ_USAGE;
        s_result_class   = RC_FOUND;
        s_request_digest = '0;
        s_usage_weight   = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_ENABLED;
        cfg_wdata        = '0;
        cur_typed        = 1'b0;
        cur_want         = '0;
        limiter_reset();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        build_script();
        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain();
                cfg_write(script[i].reg_idx, script[i].reg_val);
            end else begin
                send_word(script[i].req, script[i].rc, script[i].dig, script[i].weight,
                          script[i].typed, script[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) run_phase(ph);

        drain();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
